FILE: rtl/breakpoint_envelope_generator_defines.svh
// Assertion macros for the breakpoint envelope generator.
// Included by the top level; the enclosing module must declare clk and rst_n.
`ifndef BREAKPOINT_ENVELOPE_GENERATOR_DEFINES_SVH
`define BREAKPOINT_ENVELOPE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored during reset.
`define BPE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and ignored during reset.
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bpe_pkg.sv
// Shared types and constants for the breakpoint envelope generator.
// Used by the top level and by the serial divider; no dependencies.
package bpe_pkg;

  localparam int NUM_TRACKS = 3;

  // Divider widths: |dv * dt| is below 2^24, the divisor is a time span.
  localparam int NUM_W = 24;
  localparam int DEN_W = 16;

  // Command codes.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_INS  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_MOVE = 2'd3;

  // Track codes.
  localparam logic [1:0] TRK_VOL  = 2'd0;
  localparam logic [1:0] TRK_FREQ = 2'd1;
  localparam logic [1:0] TRK_CTRL = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EV_A,
    S_EV_B,
    S_EV_C,
    S_EV_D,
    S_EV_M,
    S_EV_W,
    S_DONE,
    S_SC_RD,
    S_SC_CHK,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DL_RD,
    S_DL_WR
  } state_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_stat_t;

endpackage

FILE: rtl/bpe_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on bpe_pkg for the operand widths and the status struct.
module bpe_div import bpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int KW = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [KW-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    shifted  = {rem_r, quo_r[NUM_W-1]};
    diff     = shifted - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = KW'(NUM_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[DEN_W]) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quotient    = quo_r;
  assign stat.done   = done_r;
  assign stat.rem_nz = (rem_r != '0);

endmodule

FILE: rtl/breakpoint_envelope_generator.sv
// Breakpoint envelope generator: three sorted breakpoint tables in one memory.
// Tick: each track is evaluated in turn (an empty track gives zero, a stepped track or the last
// point gives its value, equal times hold the earlier value, other points go through the serial
// divide), then the result is registered; edits scan or shift table entries one at a time.
// Items are taken one at a time; a result waits in an output register.
// Synchronous active-low reset clears counts, cursors, time and length; running and
// loop enable come up as one. Table memory contents are not cleared.
`include "breakpoint_envelope_generator_defines.svh"

module breakpoint_envelope_generator import bpe_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] cmd, [3:2] track, [11:4] point_value, [27:12] point_time, [31:28] point_index
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] freq_byte, [11:8] vol_byte[7:4], [12] zero, [15:13] ctrl_byte[2:0], [16] still_active, [23:17] zero
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int AW    = $clog2(NUM_TRACKS * MAX_POINTS);
  localparam int XW    = (CW > 4) ? CW : 4;
  localparam int DEPTH = NUM_TRACKS * MAX_POINTS;

  // Each memory word holds {time[15:0], value[7:0]}.
  logic [23:0] bp_mem [DEPTH];
  logic [23:0] bp_rd_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [23:0]   mem_wd;
  logic [AW-1:0] mem_ra;

  state_t state_r, state_nxt;

  logic [CW-1:0] bp_count_r  [NUM_TRACKS];
  logic [CW-1:0] bp_count_nxt[NUM_TRACKS];
  logic [IW-1:0] bp_cursor_r  [NUM_TRACKS];
  logic [IW-1:0] bp_cursor_nxt[NUM_TRACKS];
  logic [15:0] now_r, now_nxt;
  logic [15:0] env_r, env_nxt;
  logic        running_r, running_nxt;
  logic        loop_en_r;

  // Latched command.
  logic [1:0]  cmd_r, cmd_nxt;
  logic [1:0]  trk_r, trk_nxt;
  logic [7:0]  val_r, val_nxt;
  logic [15:0] tm_r, tm_nxt;

  // Sequencer working registers.
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] c_r, c_nxt;
  logic [1:0]    ev_k_r, ev_k_nxt;
  logic [7:0]    v1_r, v1_nxt;
  logic [15:0]   t1_r, t1_nxt;
  logic [15:0]   dt_r, dt_nxt;
  logic signed [25:0] num_r, num_nxt;
  logic          neg_r, neg_nxt;
  logic [7:0]    freq_r, freq_nxt;
  logic [7:0]    vol_r, vol_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  // Divider.
  logic             div_start;
  logic [NUM_W-1:0] div_dividend;
  logic [NUM_W-1:0] div_quo;
  div_stat_t        div_stat;

  // Input fields.
  logic [1:0]  in_cmd;
  logic [1:0]  in_trk;
  logic [7:0]  in_val;
  logic [15:0] in_tm;
  logic [3:0]  in_idx;
  logic        in_acc;
  logic [CW-1:0] n_in;

  // Combinational helpers.
  logic [1:0]    ev_trk;
  logic [CW-1:0] n_ev;
  logic [CW-1:0] n_ed;
  logic [CW-1:0] c_ext;
  logic [CW-1:0] c_new;
  logic [16:0]   t_inc;
  logic [15:0]   rd_time;
  logic [7:0]    rd_val;
  logic          ev_done;
  logic [7:0]    ev_res;
  logic          place;
  logic [CW-1:0] place_pos;
  logic signed [8:0]  dv;
  logic signed [16:0] dtm;
  logic signed [25:0] num_mag;
  logic signed [25:0] q_s;
  logic signed [26:0] r_s;

  function automatic logic [AW-1:0] addr_of(input logic [1:0] trk, input logic [CW-1:0] ix);
    addr_of = AW'(trk) * AW'(MAX_POINTS) + AW'(ix);
  endfunction

  assign in_cmd = in_tdata[1:0];
  assign in_trk = in_tdata[3:2];
  assign in_val = in_tdata[11:4];
  assign in_tm  = in_tdata[27:12];
  assign in_idx = in_tdata[31:28];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign rd_time = bp_rd_r[23:8];
  assign rd_val  = bp_rd_r[7:0];

  // Evaluation order is frequency, volume, then control.
  always_comb begin
    case (ev_k_r)
      2'd0:    ev_trk = TRK_FREQ;
      2'd1:    ev_trk = TRK_VOL;
      default: ev_trk = TRK_CTRL;
    endcase
  end

  assign n_in  = (in_trk < 2'(NUM_TRACKS)) ? bp_count_r[in_trk] : '0;
  assign n_ev  = bp_count_r[ev_trk];
  assign n_ed  = bp_count_r[trk_r];
  assign c_ext = CW'(c_r);

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bp_mem[mem_wa] <= mem_wd;
    end
    bp_rd_r <= bp_mem[mem_ra];
  end

  bpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dt_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    bp_count_nxt  = bp_count_r;
    bp_cursor_nxt = bp_cursor_r;
    now_nxt       = now_r;
    env_nxt       = env_r;
    running_nxt   = running_r;
    cmd_nxt       = cmd_r;
    trk_nxt       = trk_r;
    val_nxt       = val_r;
    tm_nxt        = tm_r;
    i_nxt         = i_r;
    pos_nxt       = pos_r;
    c_nxt         = c_r;
    ev_k_nxt      = ev_k_r;
    v1_nxt        = v1_r;
    t1_nxt        = t1_r;
    dt_nxt        = dt_r;
    num_nxt       = num_r;
    neg_nxt       = neg_r;
    freq_nxt      = freq_r;
    vol_nxt       = vol_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = addr_of(trk_r, i_r);
    mem_wd        = bp_rd_r;
    mem_ra        = addr_of(trk_r, i_r);
    div_start     = 1'b0;
    ev_done       = 1'b0;
    ev_res        = '0;
    place         = 1'b0;
    place_pos     = i_r;
    c_new         = c_ext;
    t_inc         = {1'b0, now_r} + 17'd1;
    dv            = $signed({1'b0, rd_val}) - $signed({1'b0, v1_r});
    dtm           = $signed({1'b0, now_r}) - $signed({1'b0, t1_r});
    num_mag       = num_r[25] ? -num_r : num_r;
    div_dividend  = num_mag[NUM_W-1:0];
    q_s           = $signed({2'b00, div_quo});
    if (neg_r) begin
      q_s = -q_s - $signed({25'd0, div_stat.rem_nz});
    end
    r_s           = $signed({19'd0, v1_r}) + $signed({q_s[25], q_s});

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_cmd;
          trk_nxt = in_trk;
          val_nxt = in_val;
          tm_nxt  = in_tm;
          if (in_cmd == CMD_TICK) begin
            if (running_r) begin
              // Advance time; at the length the envelope wraps, all cursors rewind and running takes the loop enable.
              if (t_inc >= {1'b0, env_r}) begin
                now_nxt = '0;
                for (int k = 0; k < NUM_TRACKS; k++) begin
                  bp_cursor_nxt[k] = '0;
                end
                running_nxt = loop_en_r;
              end else begin
                now_nxt = t_inc[15:0];
              end
              ev_k_nxt  = 2'd0;
              state_nxt = S_EV_A;
            end
          end else if (in_trk < 2'(NUM_TRACKS)) begin
            case (in_cmd)
              CMD_INS: begin
                if (in_tm > env_r) begin
                  env_nxt = in_tm;
                end
                i_nxt     = '0;
                state_nxt = S_SC_RD;
              end
              CMD_DEL: begin
                // Index 0 is protected.
                if (in_idx != 4'd0 && XW'(in_idx) < XW'(n_in)) begin
                  i_nxt     = CW'(in_idx);
                  state_nxt = S_DL_RD;
                end
              end
              default: begin
                if (XW'(in_idx) < XW'(n_in)) begin
                  i_nxt     = CW'(in_idx);
                  state_nxt = S_DL_RD;
                end
              end
            endcase
          end
        end
      end

      // Clamp the cursor and fetch the following point.
      S_EV_A: begin
        if (n_ev == '0) begin
          ev_done = 1'b1;
          ev_res  = '0;
        end else begin
          if (CW'(bp_cursor_r[ev_trk]) >= n_ev) begin
            c_nxt = IW'(n_ev - 1'b1);
          end else begin
            c_nxt = bp_cursor_r[ev_trk];
          end
          if (CW'(c_nxt) + 1'b1 < n_ev) begin
            mem_ra = addr_of(ev_trk, CW'(c_nxt) + 1'b1);
          end else begin
            mem_ra = addr_of(ev_trk, CW'(c_nxt));
          end
          state_nxt = S_EV_B;
        end
      end

      // Step the cursor by at most one point, then fetch the current point.
      S_EV_B: begin
        if (c_ext + 1'b1 < n_ev && rd_time <= now_r) begin
          c_new = c_ext + 1'b1;
        end
        c_nxt                 = IW'(c_new);
        bp_cursor_nxt[ev_trk] = IW'(c_new);
        mem_ra                = addr_of(ev_trk, c_new);
        state_nxt             = S_EV_C;
      end

      S_EV_C: begin
        v1_nxt = rd_val;
        t1_nxt = rd_time;
        if (ev_trk == TRK_CTRL || c_ext + 1'b1 >= n_ev) begin
          ev_done = 1'b1;
          ev_res  = rd_val;
        end else begin
          mem_ra    = addr_of(ev_trk, c_ext + 1'b1);
          state_nxt = S_EV_D;
        end
      end

      // Next point is in; equal times hold the earlier value.
      S_EV_D: begin
        if (rd_time <= t1_r) begin
          ev_done = 1'b1;
          ev_res  = v1_r;
        end else begin
          dt_nxt    = rd_time - t1_r;
          num_nxt   = 26'(dv * dtm);
          state_nxt = S_EV_M;
        end
      end

      S_EV_M: begin
        neg_nxt   = num_r[25];
        div_start = 1'b1;
        state_nxt = S_EV_W;
      end

      // Floor the quotient, add to the start value and saturate.
      S_EV_W: begin
        if (div_stat.done) begin
          ev_done = 1'b1;
          if (r_s < 0) begin
            ev_res = 8'd0;
          end else if (r_s > 27'sd255) begin
            ev_res = 8'd255;
          end else begin
            ev_res = r_s[7:0];
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, running_r, v1_r[2:0], 1'b0, vol_r[7:4], freq_r};
          state_nxt     = S_IDLE;
        end
      end

      // Find the first point later than the new time, or, for an insert, an equal one to overwrite.
      S_SC_RD: begin
        if (i_r >= n_ed) begin
          place     = 1'b1;
          place_pos = n_ed;
        end else begin
          mem_ra    = addr_of(trk_r, i_r);
          state_nxt = S_SC_CHK;
        end
      end

      S_SC_CHK: begin
        if (cmd_r == CMD_INS && rd_time == tm_r) begin
          mem_we    = 1'b1;
          mem_wa    = addr_of(trk_r, i_r);
          mem_wd    = {rd_time, val_r};
          state_nxt = S_IDLE;
        end else if (rd_time > tm_r) begin
          place     = 1'b1;
          place_pos = i_r;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SC_RD;
        end
      end

      // Open a gap at pos by moving entries up one, top first.
      S_SH_RD: begin
        mem_ra    = addr_of(trk_r, i_r - 1'b1);
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        mem_we = 1'b1;
        mem_wa = addr_of(trk_r, i_r);
        mem_wd = bp_rd_r;
        i_nxt  = i_r - 1'b1;
        if (i_r - 1'b1 > pos_r) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        mem_we              = 1'b1;
        mem_wa              = addr_of(trk_r, pos_r);
        mem_wd              = {tm_r, val_r};
        bp_count_nxt[trk_r] = n_ed + 1'b1;
        state_nxt           = S_IDLE;
      end

      // Close the gap at i by moving later entries down one.
      S_DL_RD: begin
        if (i_r + 1'b1 < n_ed) begin
          mem_ra    = addr_of(trk_r, i_r + 1'b1);
          state_nxt = S_DL_WR;
        end else begin
          bp_count_nxt[trk_r] = n_ed - 1'b1;
          if (cmd_r == CMD_MOVE) begin
            i_nxt     = '0;
            state_nxt = S_SC_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_DL_WR: begin
        mem_we    = 1'b1;
        mem_wa    = addr_of(trk_r, i_r);
        mem_wd    = bp_rd_r;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_DL_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A track finished evaluating.
    if (ev_done) begin
      case (ev_k_r)
        2'd0: begin
          freq_nxt  = ev_res;
          ev_k_nxt  = 2'd1;
          state_nxt = S_EV_A;
        end
        2'd1: begin
          vol_nxt   = ev_res;
          ev_k_nxt  = 2'd2;
          state_nxt = S_EV_A;
        end
        default: begin
          v1_nxt    = ev_res;
          state_nxt = S_DONE;
        end
      endcase
    end

    // Scan ended: a full table drops an insert; a move landing last sets the length.
    if (place) begin
      pos_nxt = place_pos;
      i_nxt   = n_ed;
      if (cmd_r == CMD_INS && n_ed >= CW'(MAX_POINTS)) begin
        state_nxt = S_IDLE;
      end else begin
        if (cmd_r == CMD_MOVE && place_pos == n_ed) begin
          env_nxt = tm_r;
        end
        if (n_ed > place_pos) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_PUT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int k = 0; k < NUM_TRACKS; k++) begin
        bp_count_r[k]  <= '0;
        bp_cursor_r[k] <= '0;
      end
      now_r       <= '0;
      env_r       <= '0;
      running_r   <= 1'b1;
      loop_en_r   <= 1'b1;
      out_valid_r <= 1'b0;
      ev_k_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      bp_count_r  <= bp_count_nxt;
      bp_cursor_r <= bp_cursor_nxt;
      now_r       <= now_nxt;
      env_r       <= env_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
      ev_k_r      <= ev_k_nxt;
      if (cfg_valid && cfg_ready) begin
        loop_en_r <= cfg_data;
      end
    end
    cmd_r      <= cmd_nxt;
    trk_r      <= trk_nxt;
    val_r      <= val_nxt;
    tm_r       <= tm_nxt;
    i_r        <= i_nxt;
    pos_r      <= pos_nxt;
    c_r        <= c_nxt;
    v1_r       <= v1_nxt;
    t1_r       <= t1_nxt;
    dt_r       <= dt_nxt;
    num_r      <= num_nxt;
    neg_r      <= neg_nxt;
    freq_r     <= freq_nxt;
    vol_r      <= vol_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A tick while stopped gives no result and leaves the sequencer idle.
  `BPE_ASSERT_NEXT(a_stopped_tick, in_acc && in_cmd == CMD_TICK && !running_r, state_r == S_IDLE, "tick while stopped started work")
  // A result appears only when a tick completes.
  `BPE_ASSERT_IMPL(a_out_source, $rose(out_valid_r), $past(state_r) == S_DONE, "result without a finished tick")
  // No table ever holds more than its capacity.
  `BPE_ASSERT_IMPL(a_count_max, 1'b1, bp_count_r[0] <= CW'(MAX_POINTS) && bp_count_r[1] <= CW'(MAX_POINTS) && bp_count_r[2] <= CW'(MAX_POINTS), "table count overflow")

endmodule
